// File: rtl/spt_pkg.sv
// Shared types, codes and constants of the stepper position tracker.
package spt_pkg;

   localparam int CPD_W      = 16;
   localparam int LOW_W      = 17;
   localparam int ANGLE_W    = 17;
   localparam int COUNT_W    = 32;
   localparam int STEP_W     = 16;
   localparam int POS_W      = 32;
   localparam int NUM_W      = 48;
   localparam int ITER_W     = $clog2(NUM_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // 25600 = 100 * 2^8: shift by 8, then divide by 100 through a reciprocal
   localparam int SCALE_SHIFT = 8;
   localparam int SCALED_W    = NUM_W - SCALE_SHIFT;
   localparam int QUOT_W      = 23;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_AZ_CPD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EL_CPD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AZ_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EL_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS = 3'd4;

   localparam logic [CPD_W-1:0]    CPD_RESET  = 16'd256;
   localparam logic [STEP_W-1:0]   STOW_STEPS = 16'd8000;
   localparam logic [STEP_W-1:0]   STEP_SAT   = 16'hFFFF;
   localparam logic [15:0]         SCALE      = 16'd25600;
   localparam logic [NUM_W-1:0]    HALF_SCALE = 48'd12800;
   localparam logic [RECIP_W-1:0]  RECIP_100  = 24'd10737419;
   localparam logic [SCALED_W-1:0] SCALED_SAT = 40'd6553600;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_PLAN   = 2'd1,
      OP_REPORT = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

   localparam logic [1:0] REPLY_OTHER = 2'd0;
   localparam logic [1:0] REPLY_MOVED = 2'd1;
   localparam logic [1:0] REPLY_DONE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_STORE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic read_el;
      logic mul;
      logic sum;
      logic div_start;
      logic store;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   stow;
      logic   div_done;
   } status_type;

endpackage

// File: rtl/spt_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module spt_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [spt_pkg::NUM_W-1:0] dividend,
   input  logic [15:0]               divisor,
   output logic                      done,
   output logic [spt_pkg::NUM_W-1:0] quotient
);
   import spt_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [15:0]       rem_ff, rem_in;
   logic [15:0]       dvs_ff, dvs_in;
   logic [16:0]       shifted;
   logic [16:0]       diff;
   logic              ge;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         rem_in  = ge ? diff[15:0] : shifted[15:0];
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/spt_datapath.sv
// Datapath: configuration, step counts, sent moves, arithmetic and result registers.
module spt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  spt_pkg::cmd_type               cmd,
   output spt_pkg::status_type            status,
   input  logic [1:0]                     req_operation,
   input  logic                           req_axis,
   input  logic signed [spt_pkg::ANGLE_W-1:0] req_target_angle,
   input  logic                           req_stow_active,
   input  logic [1:0]                     req_reply_kind,
   input  logic [spt_pkg::STEP_W-1:0]     req_reply_count,
   input  logic                           csr_write_enable,
   input  logic [spt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spt_pkg::CSR_DATA_W-1:0] csr_write_data,
   output logic                           rsp_issue_move,
   output logic                           rsp_move_positive,
   output logic [spt_pkg::STEP_W-1:0]     rsp_move_count,
   output logic signed [spt_pkg::POS_W-1:0] rsp_az_position,
   output logic signed [spt_pkg::POS_W-1:0] rsp_el_position
);
   import spt_pkg::*;

   // captured item
   op_type             op_ff, op_in;
   logic               axis_ff, axis_in;
   logic [ANGLE_W-1:0] target_ff, target_in;
   logic               stow_ff, stow_in;
   logic [1:0]         kind_ff, kind_in;
   logic [STEP_W-1:0]  reply_ff, reply_in;

   // configuration
   logic [1:0][CPD_W-1:0] cpd_ff, cpd_in;
   logic [1:0][LOW_W-1:0] low_ff, low_in;
   logic [STEP_W-1:0]     max_ff, max_in;

   // tracked state
   logic [1:0][COUNT_W-1:0] count_ff, count_in;
   logic [1:0][STEP_W-1:0]  sent_count_ff, sent_count_in;
   logic [1:0]              sent_pos_ff, sent_pos_in;
   logic [1:0]              sent_valid_ff, sent_valid_in;

   // arithmetic
   logic signed [NUM_W-1:0] prod_a_ff, prod_a_in;
   logic signed [NUM_W-1:0] prod_b_ff, prod_b_in;
   logic signed [NUM_W-1:0] lim_ff, lim_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [POS_W-1:0]        az_res_ff, az_res_in;
   logic [POS_W-1:0]        el_res_ff, el_res_in;
   logic [SCALED_W-1:0]     scaled_ff, scaled_in;
   logic [STEP_W-1:0]       plan_q_ff, plan_q_in;

   // result registers
   logic              issue_ff, issue_in;
   logic              pos_ff, pos_in;
   logic [STEP_W-1:0] mcount_ff, mcount_in;
   logic [POS_W-1:0]  az_pos_ff, az_pos_in;
   logic [POS_W-1:0]  el_pos_ff, el_pos_in;

   logic                      is_read;
   logic                      sel_axis;
   logic signed [COUNT_W-1:0] count_sel;
   logic [CPD_W-1:0]          cpd_sel;
   logic [CPD_W-1:0]          cpd_m;
   logic signed [LOW_W-1:0]   low_sel;
   logic signed [ANGLE_W:0]   diff;
   logic signed [ANGLE_W:0]   mult_a;
   logic signed [CPD_W:0]     mult_b;
   logic signed [ANGLE_W+CPD_W+1:0] prod_b_full;
   logic signed [NUM_W-1:0]   prod_a_full;
   logic [30:0]               lim_prod;
   logic signed [NUM_W-1:0]   plan_n;
   logic signed [NUM_W-1:0]   plan_clamped;
   logic [NUM_W-1:0]          mag;
   logic [NUM_W-1:0]          rounded;
   logic [RECIP_W+QUOT_W-1:0] recip_prod;
   logic                      div_go;
   logic [NUM_W-1:0]          dividend;
   logic [15:0]               divisor;
   logic                      div_done;
   logic [NUM_W-1:0]          quotient;
   logic [POS_W-1:0]          read_res;
   logic [STEP_W-1:0]         plan_cnt;
   logic                      plan_pos;
   logic [COUNT_W-1:0]        delta;

   assign is_read   = (op_ff == OP_READ);
   assign sel_axis  = is_read ? cmd.read_el : axis_ff;
   assign count_sel = $signed(count_ff[sel_axis]);
   assign cpd_sel   = cpd_ff[sel_axis];
   assign cpd_m     = (is_read && cpd_sel == '0) ? CPD_W'(1) : cpd_sel;
   assign low_sel   = $signed(low_ff[sel_axis]);
   assign diff      = $signed({target_ff[ANGLE_W-1], target_ff})
                      - $signed({low_sel[LOW_W-1], low_sel});
   assign mult_a    = is_read ? $signed({low_sel[LOW_W-1], low_sel}) : diff;
   assign mult_b    = $signed({1'b0, cpd_m});
   assign prod_b_full = mult_a * mult_b;
   assign prod_a_full = count_sel * $signed({1'b0, SCALE});
   assign lim_prod    = 31'(max_ff) * 31'(SCALE);

   assign plan_n = prod_b_ff - prod_a_ff;
   always_comb begin
      plan_clamped = plan_n;
      if (max_ff != '0) begin
         if (plan_n > lim_ff) begin
            plan_clamped = lim_ff;
         end else if (plan_n < -lim_ff) begin
            plan_clamped = -lim_ff;
         end
      end
   end

   assign mag        = num_ff[NUM_W-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
   assign rounded    = mag + HALF_SCALE;
   assign recip_prod = scaled_ff[QUOT_W-1:0] * RECIP_100;
   assign div_go     = cmd.div_start && is_read;
   assign dividend   = mag;
   assign divisor    = cpd_m;

   spt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      if (num_ff[NUM_W-1]) begin
         if (quotient > NUM_W'(64'h8000_0000)) begin
            read_res = 32'h8000_0000;
         end else begin
            read_res = POS_W'(-quotient);
         end
      end else begin
         if (quotient > NUM_W'(64'h7FFF_FFFF)) begin
            read_res = 32'h7FFF_FFFF;
         end else begin
            read_res = quotient[POS_W-1:0];
         end
      end
   end

   always_comb begin
      if (stow_ff) begin
         plan_cnt = STOW_STEPS;
         plan_pos = 1'b0;
      end else begin
         plan_cnt = plan_q_ff;
         plan_pos = !num_ff[NUM_W-1] && (plan_cnt != '0);
      end
   end

   always_comb begin
      case (kind_ff)
         REPLY_MOVED: delta = COUNT_W'(reply_ff);
         REPLY_DONE:  delta = COUNT_W'(sent_count_ff[axis_ff]);
         default:     delta = '0;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      axis_in   = axis_ff;
      target_in = target_ff;
      stow_in   = stow_ff;
      kind_in   = kind_ff;
      reply_in  = reply_ff;
      if (cmd.load_req) begin
         op_in     = op_type'(req_operation);
         axis_in   = req_axis;
         target_in = req_target_angle;
         stow_in   = req_stow_active;
         kind_in   = req_reply_kind;
         reply_in  = req_reply_count;
      end
   end

   always_comb begin
      cpd_in = cpd_ff;
      low_in = low_ff;
      max_in = max_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_AZ_CPD:    cpd_in[0] = csr_write_data[CPD_W-1:0];
            CSR_EL_CPD:    cpd_in[1] = csr_write_data[CPD_W-1:0];
            CSR_AZ_LOW:    low_in[0] = csr_write_data[LOW_W-1:0];
            CSR_EL_LOW:    low_in[1] = csr_write_data[LOW_W-1:0];
            CSR_MAX_STEPS: max_in    = csr_write_data[STEP_W-1:0];
            default:       max_in    = max_ff;
         endcase
      end
   end

   always_comb begin
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      lim_in    = lim_ff;
      num_in    = num_ff;
      az_res_in = az_res_ff;
      el_res_in = el_res_ff;
      scaled_in = scaled_ff;
      plan_q_in = plan_q_ff;
      if (cmd.mul) begin
         prod_a_in = prod_a_full;
         prod_b_in = {{(NUM_W-ANGLE_W-CPD_W-2){prod_b_full[ANGLE_W+CPD_W+1]}}, prod_b_full};
         lim_in    = $signed({{(NUM_W-31){1'b0}}, lim_prod});
      end
      if (cmd.sum) begin
         num_in = is_read ? (prod_a_ff + prod_b_ff) : plan_clamped;
      end
      if (cmd.div_start && !is_read) begin
         scaled_in = rounded[NUM_W-1:SCALE_SHIFT];
      end
      if (cmd.store) begin
         if (!is_read) begin
            plan_q_in = (scaled_ff >= SCALED_SAT) ? STEP_SAT
                        : recip_prod[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
         end else if (cmd.read_el) begin
            el_res_in = read_res;
         end else begin
            az_res_in = read_res;
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      sent_count_in = sent_count_ff;
      sent_pos_in   = sent_pos_ff;
      sent_valid_in = sent_valid_ff;
      issue_in      = issue_ff;
      pos_in        = pos_ff;
      mcount_in     = mcount_ff;
      az_pos_in     = az_pos_ff;
      el_pos_in     = el_pos_ff;
      if (cmd.out_load) begin
         issue_in  = 1'b0;
         pos_in    = 1'b0;
         mcount_in = '0;
         az_pos_in = '0;
         el_pos_in = '0;
         case (op_ff)
            OP_READ: begin
               az_pos_in = az_res_ff;
               el_pos_in = el_res_ff;
            end
            OP_PLAN: begin
               sent_valid_in[axis_ff] = (plan_cnt != '0);
               sent_count_in[axis_ff] = plan_cnt;
               sent_pos_in[axis_ff]   = plan_pos;
               issue_in  = (plan_cnt != '0);
               pos_in    = plan_pos;
               mcount_in = plan_cnt;
            end
            OP_REPORT: begin
               if (sent_valid_ff[axis_ff]) begin
                  if (sent_pos_ff[axis_ff]) begin
                     count_in[axis_ff] = count_ff[axis_ff] + delta;
                  end else begin
                     count_in[axis_ff] = count_ff[axis_ff] - delta;
                  end
                  sent_valid_in[axis_ff] = 1'b0;
               end
            end
            OP_FINISH: begin
               if (stow_ff) begin
                  count_in = '0;
               end
            end
            default: begin
               issue_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpd_ff        <= {CPD_RESET, CPD_RESET};
         low_ff        <= '0;
         max_ff        <= '0;
         count_ff      <= '0;
         sent_count_ff <= '0;
         sent_pos_ff   <= '0;
         sent_valid_ff <= '0;
      end else begin
         cpd_ff        <= cpd_in;
         low_ff        <= low_in;
         max_ff        <= max_in;
         count_ff      <= count_in;
         sent_count_ff <= sent_count_in;
         sent_pos_ff   <= sent_pos_in;
         sent_valid_ff <= sent_valid_in;
      end
      op_ff     <= op_in;
      axis_ff   <= axis_in;
      target_ff <= target_in;
      stow_ff   <= stow_in;
      kind_ff   <= kind_in;
      reply_ff  <= reply_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      lim_ff    <= lim_in;
      num_ff    <= num_in;
      az_res_ff <= az_res_in;
      el_res_ff <= el_res_in;
      scaled_ff <= scaled_in;
      plan_q_ff <= plan_q_in;
      issue_ff  <= issue_in;
      pos_ff    <= pos_in;
      mcount_ff <= mcount_in;
      az_pos_ff <= az_pos_in;
      el_pos_ff <= el_pos_in;
   end

   assign status.op       = op_ff;
   assign status.stow     = stow_ff;
   assign status.div_done = div_done;

   assign rsp_issue_move    = issue_ff;
   assign rsp_move_positive = pos_ff;
   assign rsp_move_count    = mcount_ff;
   assign rsp_az_position   = $signed(az_pos_ff);
   assign rsp_el_position   = $signed(el_pos_ff);

endmodule

// File: rtl/spt_controller.sv
// Controller state machine: sequences one item and owns the handshakes.
module spt_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  spt_pkg::status_type status,
   output spt_pkg::cmd_type    cmd
);
   import spt_pkg::*;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            second_in = 1'b0;
            if (status.op == OP_READ || (status.op == OP_PLAN && !status.stow)) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_MUL:       state_in = ST_SUM;
         ST_SUM:       state_in = ST_DIV_START;
         ST_DIV_START: state_in = (status.op == OP_READ) ? ST_DIV_WAIT : ST_STORE;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (status.op == OP_READ && !second_ff) begin
               second_in = 1'b1;
               state_in  = ST_MUL;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.read_el   = second_ff;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         ST_MUL:       cmd.mul       = 1'b1;
         ST_SUM:       cmd.sum       = 1'b1;
         ST_DIV_START: cmd.div_start = 1'b1;
         ST_STORE:     cmd.store     = 1'b1;
         ST_OUTPUT:    cmd.out_load  = out_free;
         default:      req_stall     = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while an item is still in work");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside the wait state");

   a_second_pass_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE && second_ff |-> status.op == OP_READ)
      else $error("second divide pass on a non-read item");

   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUTPUT)
      else $error("result raised outside the output state");

endmodule

// File: rtl/stepper_position_tracker.sv
// Top level of the two-axis stepper position tracker.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   operation, axis, target, stow, reply
//   rsp      out        rsp_valid/rsp_stall   move fields, az and el positions
//   csr      in         csr_write_enable      csr_index, csr_write_data
//
// One item at a time. A read runs one bit-serial divide by counts per degree for each
// axis, each pass yielding a 48-bit quotient. A plan needs no divider: the divide by
// 25600 is a shift and a reciprocal multiply. Stow plans, reports and finishes skip the
// arithmetic and go straight to output.
// Reset is synchronous; counts, sent moves and configuration registers take reset values.
// A new item is taken while a finished result waits under rsp_stall.
module stepper_position_tracker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic                           req_axis,
   input  logic signed [spt_pkg::ANGLE_W-1:0] req_target_angle,
   input  logic                           req_stow_active,
   input  logic [1:0]                     req_reply_kind,
   input  logic [spt_pkg::STEP_W-1:0]     req_reply_count,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_issue_move,
   output logic                           rsp_move_positive,
   output logic [spt_pkg::STEP_W-1:0]     rsp_move_count,
   output logic signed [spt_pkg::POS_W-1:0] rsp_az_position,
   output logic signed [spt_pkg::POS_W-1:0] rsp_el_position,
   input  logic                           csr_write_enable,
   input  logic [spt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spt_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import spt_pkg::*;

   cmd_type    cmd;
   status_type status;

   spt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   spt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_axis          (req_axis),
      .req_target_angle  (req_target_angle),
      .req_stow_active   (req_stow_active),
      .req_reply_kind    (req_reply_kind),
      .req_reply_count   (req_reply_count),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_issue_move    (rsp_issue_move),
      .rsp_move_positive (rsp_move_positive),
      .rsp_move_count    (rsp_move_count),
      .rsp_az_position   (rsp_az_position),
      .rsp_el_position   (rsp_el_position)
   );

endmodule
